// File: design/l2db_pkg.sv
// Shared types, widths and codes of the squared-L2 distance batch engine.
// Standalone package; imported by l2_distance_batch_engine_core.
package l2db_pkg;

  // Default geometry
  localparam int MAX_DIM_DEF      = 1024;
  localparam int ELEMENT_BITS_DEF = 16;

  // Fixed field widths
  localparam int ELEM_W  = 16;
  localparam int NORM_W  = 41;
  localparam int LEN_W   = 11;
  localparam int MODE_W  = 2;
  localparam int ACC_W   = 48;
  localparam int SCORE_W = 44;
  localparam int ROW_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Stream payload widths (packed, padded to whole bytes)
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;

  // Internal score arithmetic width and saturation bound (2^42)
  localparam int BASE_W = NORM_W + 1;
  localparam int CALC_W = ACC_W + 3;
  localparam logic signed [CALC_W-1:0] SCORE_MAX = CALC_W'(64'sd4398046511104);

  // Command codes carried in tuser
  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_ROW  = 1'b1
  } cmd_t;

  // Score modes
  typedef enum logic [MODE_W-1:0] {
    MODE_L2       = 2'd0,
    MODE_HALFNORM = 2'd1,
    MODE_DOT      = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VECTOR_LENGTH = 2'd0,
    CFG_SCORE_MODE    = 2'd1,
    CFG_QUERY_NORM    = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

endpackage

// File: design/l2_distance_batch_engine_core.sv
// Squared-L2 / dot product batch engine: query store, MAC pipeline, score stage.
// Depends on l2db_pkg for widths, command, mode and register codes.
//
// Channel | Direction | Handshake           | Payload
// in_     | slave     | in_tvalid/in_tready | tdata: element_value, row_norm; tuser: cmd
// out_    | master    | out_tvalid/out_tready | tdata: score, row_index
// cfg_    | write     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled: one query store read
// and one multiply-accumulate per element. After its last element is accepted, a row
// passes store read, multiply, accumulate, then score into the output register.
// rst_n is synchronous and clears counters, accumulator, valids and configuration
// registers; the query store is not cleared. A stalled output freezes the whole pipeline,
// so in_tready follows out_tready whenever a result is held.
module l2_distance_batch_engine_core #(
  parameter int MAX_DIM      = l2db_pkg::MAX_DIM_DEF,
  parameter int ELEMENT_BITS = l2db_pkg::ELEMENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [l2db_pkg::IN_DATA_W-1:0]    in_tdata,   // element_value[15:0], row_norm[56:16]
  input  logic                              in_tuser,   // cmd[0]
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [l2db_pkg::OUT_DATA_W-1:0]   out_tdata,  // score[43:0], row_index[59:44]
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [l2db_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [l2db_pkg::NORM_W-1:0]       cfg_data
);
  import l2db_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam int PW = 2 * ELEMENT_BITS;

  // Configuration registers
  logic [LEN_W-1:0]  vlen_r;
  logic [MODE_W-1:0] mode_r;
  logic [NORM_W-1:0] qnorm_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r  <= LEN_W'(1);
      mode_r  <= MODE_L2;
      qnorm_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VECTOR_LENGTH: vlen_r  <= cfg_data[LEN_W-1:0];
        CFG_SCORE_MODE:    mode_r  <= cfg_data[MODE_W-1:0];
        CFG_QUERY_NORM:    qnorm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective length, clamped to 1..MAX_DIM
  logic [CW-1:0] len_eff;
  always_comb begin
    if (vlen_r == '0) begin
      len_eff = CW'(1);
    end else if (CW'(vlen_r) > CW'(MAX_DIM)) begin
      len_eff = CW'(MAX_DIM);
    end else begin
      len_eff = CW'(vlen_r);
    end
  end

  // Unpack input transaction
  logic [ELEM_W-1:0] in_elem;
  logic [NORM_W-1:0] in_rnorm;
  logic              in_is_row;
  assign in_elem   = in_tdata[ELEM_W-1:0];
  assign in_rnorm  = in_tdata[ELEM_W+NORM_W-1:ELEM_W];
  assign in_is_row = (cmd_t'(in_tuser) == CMD_ROW);

  // Pipeline advances whenever the output register can take a result
  logic adv, in_acc;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // Stage 0: pointers, counters, row numbering
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [ROW_W-1:0] rowc_r, rowc_nxt;
  logic             row_last;

  always_comb begin
    ptr_nxt  = ptr_r;
    cnt_nxt  = cnt_r;
    rowc_nxt = rowc_r;
    row_last = (CW'(cnt_r) + CW'(1)) >= len_eff;
    if (in_acc) begin
      if (!in_is_row) begin
        ptr_nxt  = ((CW'(ptr_r) + CW'(1)) >= len_eff) ? '0 : AW'(ptr_r + AW'(1));
        cnt_nxt  = '0;
        rowc_nxt = '0;
      end else if (row_last) begin
        cnt_nxt  = '0;
        rowc_nxt = rowc_r + ROW_W'(1);
      end else begin
        cnt_nxt  = cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      cnt_r  <= '0;
      rowc_r <= '0;
    end else begin
      ptr_r  <= ptr_nxt;
      cnt_r  <= cnt_nxt;
      rowc_r <= rowc_nxt;
    end
  end

  // Query store: write on load, read at the element counter
  logic [ELEMENT_BITS-1:0] qmem [MAX_DIM];
  logic [ELEMENT_BITS-1:0] qrd_r;

  always_ff @(posedge clk) begin
    if (in_acc && !in_is_row) begin
      qmem[ptr_r] <= ELEMENT_BITS'(in_elem);
    end
    if (adv) begin
      qrd_r <= qmem[cnt_r];
    end
  end

  // Stage 1 registers
  logic                    s1_v_r, s1_row_r, s1_last_r;
  logic [ELEMENT_BITS-1:0] s1_elem_r;
  logic [NORM_W-1:0]       s1_rnorm_r;
  logic [ROW_W-1:0]        s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_row_r   <= in_is_row;
      s1_last_r  <= row_last;
      s1_elem_r  <= ELEMENT_BITS'(in_elem);
      s1_rnorm_r <= in_rnorm;
      s1_idx_r   <= rowc_r;
    end
  end

  // Stage 2: multiply, prepare the norm term
  logic                    s2_v_r, s2_row_r, s2_last_r;
  logic signed [PW-1:0]    prod_r;
  logic [BASE_W-1:0]       s2_base_r;
  logic [ROW_W-1:0]        s2_idx_r;
  logic [BASE_W-1:0]       base_nxt;

  always_comb begin
    if (mode_t'(mode_r) == MODE_L2) begin
      base_nxt = BASE_W'(qnorm_r) + BASE_W'(s1_rnorm_r);
    end else begin
      base_nxt = BASE_W'(s1_rnorm_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_row_r  <= s1_row_r;
      s2_last_r <= s1_last_r;
      prod_r    <= $signed(qrd_r) * $signed(s1_elem_r);
      s2_base_r <= base_nxt;
      s2_idx_r  <= s1_idx_r;
    end
  end

  // Stage 3: accumulate; a load or a finished row clears the accumulator
  logic signed [ACC_W-1:0] prod_ext;
  logic [ACC_W-1:0]        acc_r, acc_sum;
  logic                    s3_v_r;
  logic [ACC_W-1:0]        dot_r;
  logic [BASE_W-1:0]       s3_base_r;
  logic [ROW_W-1:0]        s3_idx_r;

  assign prod_ext = ACC_W'(prod_r);
  assign acc_sum  = acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r && s2_row_r && s2_last_r;
      if (s2_v_r) begin
        if (!s2_row_r || s2_last_r) begin
          acc_r <= '0;
        end else begin
          acc_r <= acc_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_r     <= acc_sum;
      s3_base_r <= s2_base_r;
      s3_idx_r  <= s2_idx_r;
    end
  end

  // Stage 4: score by mode, clamp, hold for the consumer
  logic signed [CALC_W-1:0] dot_s, base_s, raw_s, sat_s;
  logic [SCORE_W-1:0]       score_r;
  logic [ROW_W-1:0]         oidx_r;
  logic                     out_v_r;

  assign dot_s  = CALC_W'($signed(dot_r));
  assign base_s = $signed(CALC_W'(s3_base_r));

  always_comb begin
    case (mode_t'(mode_r))
      MODE_L2:       raw_s = base_s - (dot_s <<< 1);
      MODE_HALFNORM: raw_s = dot_s - base_s;
      default:       raw_s = dot_s;
    endcase
    if (mode_t'(mode_r) == MODE_L2 && raw_s < 0) begin
      sat_s = '0;
    end else if (raw_s > SCORE_MAX) begin
      sat_s = SCORE_MAX;
    end else if (raw_s < -SCORE_MAX) begin
      sat_s = -SCORE_MAX;
    end else begin
      sat_s = raw_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      score_r <= sat_s[SCORE_W-1:0];
      oidx_r  <= s3_idx_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W - SCORE_W - ROW_W){1'b0}}, oidx_r, score_r};

endmodule
